FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the command parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`endif

FILE: hw/rtl/vgmdmg_pkg.sv
// Types and constants of the command stream parser.
package vgmdmg_pkg;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       last_of_pass;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_address;
        logic [7:0]  reg_value;
        logic [63:0] target_time;
    } out_item_t;

    localparam logic [2:0] PH_CMD     = 3'd0;
    localparam logic [2:0] PH_WR_ADDR = 3'd1;
    localparam logic [2:0] PH_WR_DATA = 3'd2;
    localparam logic [2:0] PH_CNT_LO  = 3'd3;
    localparam logic [2:0] PH_CNT_HI  = 3'd4;
    localparam logic [2:0] PH_STOPPED = 3'd5;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_WAIT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CMD_WRITE     = 8'hb3;
    localparam logic [7:0] CMD_WAIT_N    = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
    localparam logic [7:0] CMD_END       = 8'h66;
    localparam logic [7:0] CMD_SHORT_LO  = 8'h70;
    localparam logic [7:0] CMD_SHORT_HI  = 8'h7f;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0f;

    localparam logic [15:0] SAMPLES_NTSC = 16'd735;
    localparam logic [15:0] SAMPLES_PAL  = 16'd882;

endpackage

FILE: hw/rtl/vgm_dmg_command_parser_top.sv
// Top level of the command stream parser: input register, decode and result register.
//
// The block reads a command stream one byte per item on the s_ channel and
// produces register writes, wait-until times and end markers on the m_ channel.
// Each input item carries one stream byte and a flag that marks the last byte
// of a playback pass; the parse phase returns to command position after it.
// Each wait adds to a 64-bit sample-time total that carries across passes.
// A byte enters an input register, is decoded from there together with the
// 64-bit time add, and any result is written to the output register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single decode and add stage.
// Bytes that yield no result put no item into the output stream.
// When the receiver stalls, the result stays in the output register, one more
// item waits in the input register, and s_ready falls until m_ready returns.
// Reset clears both valid flags, the parse phase, the held bytes and the
// sample-time total.
module vgm_dmg_command_parser_top
    import vgmdmg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

`include "assert_macros.svh"

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    out_item_t   m_item_reg;
    out_item_t   m_item_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [7:0]  held_address_reg;
    logic [7:0]  held_address_next;
    logic [7:0]  held_low_count_reg;
    logic [7:0]  held_low_count_next;
    logic [63:0] sample_time_reg;
    logic [63:0] sample_time_next;
    logic        out_free;
    logic        advance;
    logic        emit;
    logic        is_wait;
    logic [15:0] wait_amount;
    logic [7:0]  b;
    logic [63:0] time_sum;
    logic        wait_time_ok;
    logic        write_time_ok;
    logic        pass_end;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign b        = in_item_reg.stream_byte;
    assign time_sum = sample_time_reg + {48'd0, wait_amount};

    always_comb begin
        phase_next          = phase_reg;
        held_address_next   = held_address_reg;
        held_low_count_next = held_low_count_reg;
        emit                = 1'b0;
        is_wait             = 1'b0;
        wait_amount         = 16'd0;
        m_item_next         = '0;
        case (phase_reg)
            PH_WR_ADDR: begin
                held_address_next = b;
                phase_next        = PH_WR_DATA;
            end
            PH_WR_DATA: begin
                emit                    = 1'b1;
                m_item_next.kind        = KIND_WRITE;
                m_item_next.reg_address = held_address_reg;
                m_item_next.reg_value   = b;
                phase_next              = PH_CMD;
            end
            PH_CNT_LO: begin
                held_low_count_next = b;
                phase_next          = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                is_wait     = 1'b1;
                wait_amount = {b, held_low_count_reg};
                phase_next  = PH_CMD;
            end
            PH_STOPPED: begin
                phase_next = PH_STOPPED;
            end
            default: begin
                phase_next = PH_CMD;
                if (b == CMD_WRITE) begin
                    phase_next = PH_WR_ADDR;
                end else if (b == CMD_WAIT_N) begin
                    phase_next = PH_CNT_LO;
                end else if (b == CMD_WAIT_NTSC) begin
                    is_wait     = 1'b1;
                    wait_amount = SAMPLES_NTSC;
                end else if (b == CMD_WAIT_PAL) begin
                    is_wait     = 1'b1;
                    wait_amount = SAMPLES_PAL;
                end else if (b == CMD_END) begin
                    emit             = 1'b1;
                    m_item_next.kind = KIND_END;
                    phase_next       = PH_STOPPED;
                end else if (b >= CMD_SHORT_LO && b <= CMD_SHORT_HI) begin
                    is_wait     = 1'b1;
                    wait_amount = {8'd0, b & NIBBLE_MASK} + 16'd1;
                end
            end
        endcase
        sample_time_next = sample_time_reg;
        if (is_wait) begin
            emit                    = 1'b1;
            m_item_next.kind        = KIND_WAIT;
            m_item_next.target_time = time_sum;
            sample_time_next        = time_sum;
        end
        if (in_item_reg.last_of_pass) begin
            phase_next = PH_CMD;
        end
        m_valid_next = emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            phase_reg          <= PH_CMD;
            held_address_reg   <= 8'd0;
            held_low_count_reg <= 8'd0;
            sample_time_reg    <= 64'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg        <= m_valid_next;
                phase_reg          <= phase_next;
                held_address_reg   <= held_address_next;
                held_low_count_reg <= held_low_count_next;
                sample_time_reg    <= sample_time_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance && m_valid_next) begin
            m_item_reg <= m_item_next;
        end
    end

    assign wait_time_ok  = !(m_valid_reg && m_item_reg.kind == KIND_WAIT)
                           || m_item_reg.target_time == sample_time_reg;
    assign write_time_ok = !(m_valid_reg && m_item_reg.kind == KIND_WRITE)
                           || m_item_reg.target_time == 64'd0;
    assign pass_end      = advance && in_item_reg.last_of_pass;

    `ASSERT_ALWAYS(a_wait_time_matches, aclk, aresetn, wait_time_ok)
    `ASSERT_ALWAYS(a_write_no_time, aclk, aresetn, write_time_ok)
    `ASSERT_NEXT(a_stopped_silent, aclk, aresetn, advance && phase_reg == PH_STOPPED, !m_valid_reg)
    `ASSERT_NEXT(a_pass_end_phase, aclk, aresetn, pass_end, phase_reg == PH_CMD)

endmodule

FILE: verif/vgm_dmg_command_parser_top_tb.sv
// Self-checking testbench of the command stream parser with a scoreboard and random byte streams.
module vgm_dmg_command_parser_top_tb;
    import vgmdmg_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1150;

    class command_scoreboard;
        logic [2:0]  phase = PH_CMD;
        logic [7:0]  held_addr = '0;
        logic [7:0]  held_low = '0;
        logic [63:0] sample_total = '0;
        out_item_t   pending[$];
        int          errors = 0;
        int          n_writes = 0;
        int          n_waits = 0;
        int          n_ends = 0;

        function void push_result(logic [1:0] kind, logic [7:0] addr, logic [7:0] val,
                                  logic [63:0] t);
            out_item_t r;
            r.kind = kind;
            r.reg_address = addr;
            r.reg_value = val;
            r.target_time = t;
            pending.push_back(r);
        endfunction

        function void add_wait(logic [63:0] samples);
            sample_total = sample_total + samples;
            push_result(KIND_WAIT, 8'd0, 8'd0, sample_total);
            n_waits++;
        endfunction

        // Returns 0 when the byte falls after an end marker and is ignored.
        function bit note_input(in_item_t it);
            logic [7:0] b;
            bit         used;
            b = it.stream_byte;
            used = 1'b1;
            case (phase)
                PH_WR_ADDR: begin
                    held_addr = b;
                    phase = PH_WR_DATA;
                end
                PH_WR_DATA: begin
                    push_result(KIND_WRITE, held_addr, b, 64'd0);
                    n_writes++;
                    phase = PH_CMD;
                end
                PH_CNT_LO: begin
                    held_low = b;
                    phase = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    add_wait({48'd0, b, held_low});
                    phase = PH_CMD;
                end
                PH_STOPPED: begin
                    used = 1'b0;
                end
                default: begin
                    phase = PH_CMD;
                    if (b == CMD_WRITE) begin
                        phase = PH_WR_ADDR;
                    end else if (b == CMD_WAIT_N) begin
                        phase = PH_CNT_LO;
                    end else if (b == CMD_WAIT_NTSC) begin
                        add_wait({48'd0, SAMPLES_NTSC});
                    end else if (b == CMD_WAIT_PAL) begin
                        add_wait({48'd0, SAMPLES_PAL});
                    end else if (b == CMD_END) begin
                        push_result(KIND_END, 8'd0, 8'd0, 64'd0);
                        n_ends++;
                        phase = PH_STOPPED;
                    end else if (b >= CMD_SHORT_LO && b <= CMD_SHORT_HI) begin
                        add_wait({56'd0, b & NIBBLE_MASK} + 64'd1);
                    end
                end
            endcase
            if (it.last_of_pass) begin
                phase = PH_CMD;
            end
            return used;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report($sformatf("result kind %0d arrived with nothing expected", got.kind));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            end
            if (got.reg_address !== want.reg_address) begin
                report($sformatf("reg_address %h, expected %h",
                                 got.reg_address, want.reg_address));
            end
            if (got.reg_value !== want.reg_value) begin
                report($sformatf("reg_value %h, expected %h", got.reg_value, want.reg_value));
            end
            if (got.target_time !== want.target_time) begin
                report($sformatf("target_time %0d, expected %0d",
                                 got.target_time, want.target_time));
            end
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    command_scoreboard board;
    int cycle_count = 0;
    int burst_left = 0;
    int active_items = 0;
    int sent_items = 0;
    int stall_mode = 0;
    int stall_left = 0;

    vgm_dmg_command_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_item);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(64, 256);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((cycle_count % 13) < 4);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        int       gap;
        it.stream_byte = b;
        it.last_of_pass = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        if (board.note_input(it)) begin
            active_items++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_command();
        int         pick;
        logic [7:0] cut;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_byte(CMD_WRITE, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end else if (pick < 45) begin
            send_byte(CMD_WAIT_N, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end else if (pick < 52) begin
            send_byte(CMD_WAIT_NTSC, $urandom_range(0, 19) == 0);
        end else if (pick < 58) begin
            send_byte(CMD_WAIT_PAL, $urandom_range(0, 19) == 0);
        end else if (pick < 75) begin
            send_byte(CMD_SHORT_LO | 8'($urandom_range(0, 15)), $urandom_range(0, 19) == 0);
        end else if (pick < 80) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(CMD_END, 1'b1);
            end else begin
                send_byte(CMD_END, 1'b0);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end else if (pick < 90) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            cut = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_WAIT_N;
            send_byte(cut, $urandom_range(0, 3) == 0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(CMD_WRITE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(CMD_WRITE, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CMD_WAIT_N, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CMD_WAIT_N, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(CMD_WAIT_NTSC, 1'b0);
        send_byte(CMD_WAIT_PAL, 1'b0);
        send_byte(CMD_SHORT_LO, 1'b0);
        send_byte(CMD_SHORT_HI, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h6f, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(CMD_WRITE, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(CMD_WAIT_N, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(CMD_END, 1'b0);
        send_byte(CMD_WAIT_NTSC, 1'b0);
        send_byte(CMD_SHORT_HI, 1'b1);
        wait_drained();

        active_items = 0;
        while (active_items < RANDOM_ITEMS) begin
            send_random_command();
            if ($urandom_range(0, 199) == 0) begin
                wait_drained();
            end
        end
        wait_drained();

        while (board.pending.size() != 0) begin
            board.report("expected result never arrived");
            void'(board.pending.pop_front());
        end
        $display("Sent %0d stream bytes with random gaps and receiver stalls.", sent_items);
        $display("Checked %0d register writes, %0d waits and %0d end markers.",
                 board.n_writes, board.n_waits, board.n_ends);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
